@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the RTC calendar time keeper
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define RTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define RTC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ design/rtc_pkg.sv @@
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, constants and helper functions of the RTC calendar keeper.
// ----------------------------------------------------------------------------
`default_nettype none

package rtc_pkg;

  localparam int unsigned TpsW      = 16;
  localparam logic [TpsW-1:0] TpsReset = 16'd100;
  localparam int unsigned InDataW   = 64;
  localparam int unsigned OutDataW  = 48;
  localparam int unsigned DivSteps  = 10;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic start;
    logic step_sec;
    logic step_min;
    logic step_hr;
    logic step_day;
    logic out_load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic advance;
    logic day_done;
    logic out_full;
  } ctrl_sts_t;

  typedef struct packed {
    logic [3:0] q;
    logic [8:0] r;
  } div_res_t;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    return 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
  endfunction

  // quotient and remainder of a small value by a small constant, by compares
  function automatic div_res_t div_small(input logic [8:0] v, input logic [5:0] d);
    div_res_t res;
    res.q = '0;
    for (int k = 1; k <= DivSteps; k++) begin
      if (10'(v) >= 10'(k) * 10'(d)) res.q = res.q + 4'd1;
    end
    res.r = v - 9'(res.q) * 9'(d);
    return res;
  endfunction

  function automatic logic [4:0] days_in_month(input logic [7:0] m, input logic leap);
    logic [4:0] dim;
    if (m == 8'd2) begin
      dim = leap ? 5'd29 : 5'd28;
    end else if (m == 8'd4 || m == 8'd6 || m == 8'd9 || m == 8'd11) begin
      dim = 5'd30;
    end else begin
      dim = 5'd31;
    end
    return dim;
  endfunction

endpackage

`default_nettype wire

@@ design/rtc_ctrl.sv @@
// ----------------------------------------------------------------------------
// rtc_ctrl
// Sequencer: takes a request, runs decode/tick and (for a load or a new
// second) the carry steps and month loop, then loads the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rtc_ctrl
  import rtc_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      s_tvalid_i,
  output logic           s_tready_o,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SEC,
    S_MIN,
    S_HR,
    S_DAY,
    S_OUT
  } state_e;

  state_e state_q;

  assign s_tready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = s_tvalid_i && (state_q == S_IDLE);
    cmd_o.start    = (state_q == S_START);
    cmd_o.step_sec = (state_q == S_SEC);
    cmd_o.step_min = (state_q == S_MIN);
    cmd_o.step_hr  = (state_q == S_HR);
    cmd_o.step_day = (state_q == S_DAY);
    cmd_o.out_load = (state_q == S_OUT) && !sts_i.out_full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:  if (s_tvalid_i) state_q <= S_START;
        S_START: state_q <= sts_i.advance ? S_SEC : S_OUT;
        S_SEC:   state_q <= S_MIN;
        S_MIN:   state_q <= S_HR;
        S_HR:    state_q <= S_DAY;
        S_DAY:   if (sts_i.day_done) state_q <= S_OUT;
        S_OUT:   if (!sts_i.out_full) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `RTC_ASSERT_IMPL(a_accept_starts, s_tvalid_i && s_tready_o, ##1 (state_q == S_START), "accepted request did not start")
  `RTC_ASSERT(a_one_result, cmd_o.out_load |=> (state_q == S_IDLE) && !cmd_o.out_load, "result loaded twice for one request")
  `RTC_ASSERT_IMPL(a_carry_after_start, state_q == S_SEC, $past(state_q) == S_START && $past(sts_i.advance), "carry steps without a second to add")

endmodule

`default_nettype wire

@@ design/rtc_dp.sv @@
// ----------------------------------------------------------------------------
// rtc_dp
// Datapath: snapshot decode, tick counter, carry through the time units,
// leap-aware month loop and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rtc_dp
  import rtc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [TpsW-1:0]     cfg_wdata_i,
  input  wire logic [InDataW-1:0]  s_tdata_i,
  input  wire logic                s_tuser_i,
  input  wire logic                m_tready_i,
  input  wire ctrl_cmd_t           cmd_i,
  output ctrl_sts_t                sts_o,
  output logic                     m_tvalid_o,
  output logic [OutDataW-1:0]      m_tdata_o,
  output logic                     m_tuser_o
);

  // captured request
  logic [InDataW-1:0] raw_q;
  cmd_e               kind_q;

  // calendar state, widened where the load may be out of range
  logic [TpsW-1:0] tps_q;
  logic [TpsW-1:0] sub_q;
  logic [13:0]     year_q;
  logic [6:0]      ymod_q;    // year mod 100
  logic [1:0]      ycent_q;   // (year / 100) mod 4
  logic [7:0]      month_q;
  logic [8:0]      day_q;
  logic [8:0]      hour_q;
  logic [8:0]      min_q;
  logic [7:0]      sec_q;
  logic            loaded_q;

  logic                m_valid_q;
  logic [OutDataW-1:0] m_data_q;
  logic                m_user_q;

  // snapshot decode
  logic       twelve, binary, pm;
  logic [7:0] stb;
  logic [7:0] hr_raw, hr_dec;
  logic [8:0] hr_fix;
  logic [7:0] sec_dec, min_dec, day_dec, mon_dec, yr_dec, cent_dec;
  logic [6:0] cent_fix;
  logic [1:0] yr_hund;
  logic [6:0] yr_rem;
  logic [13:0] year_load;
  logic [1:0]  ycent_load;

  always_comb begin
    stb    = raw_q[63:56];
    twelve = !stb[1];
    binary = stb[2];
    pm     = twelve && raw_q[23];
    hr_raw = twelve ? {1'b0, raw_q[22:16]} : raw_q[23:16];

    sec_dec  = binary ? raw_q[7:0]   : bcd_to_bin(raw_q[7:0]);
    min_dec  = binary ? raw_q[15:8]  : bcd_to_bin(raw_q[15:8]);
    hr_dec   = binary ? hr_raw       : bcd_to_bin(hr_raw);
    day_dec  = binary ? raw_q[31:24] : bcd_to_bin(raw_q[31:24]);
    mon_dec  = binary ? raw_q[39:32] : bcd_to_bin(raw_q[39:32]);
    yr_dec   = binary ? raw_q[47:40] : bcd_to_bin(raw_q[47:40]);
    cent_dec = binary ? raw_q[55:48] : bcd_to_bin(raw_q[55:48]);

    hr_fix = {1'b0, hr_dec};
    if (twelve) begin
      if (hr_dec == 8'd12) begin
        hr_fix = pm ? 9'd12 : 9'd0;
      end else if (pm) begin
        hr_fix = {1'b0, hr_dec} + 9'd12;
      end
    end

    cent_fix = (cent_dec < 8'd19 || cent_dec > 8'd99) ? 7'd20 : cent_dec[6:0];

    if (yr_dec >= 8'd200) begin
      yr_hund = 2'd2;
    end else if (yr_dec >= 8'd100) begin
      yr_hund = 2'd1;
    end else begin
      yr_hund = 2'd0;
    end
    yr_rem     = 7'(yr_dec - 8'(yr_hund) * 8'd100);
    year_load  = 14'(cent_fix) * 14'd100 + 14'(yr_dec);
    ycent_load = cent_fix[1:0] + yr_hund;
  end

  // tick and carry helpers
  logic [TpsW-1:0] sub_inc;
  logic            tick_roll;
  div_res_t        div_sec, div_min, div_hr;
  logic            leap;
  logic [4:0]      dim;
  logic [7:0]      month_inc;

  assign sub_inc   = sub_q + 16'd1;
  assign tick_roll = (sub_inc >= tps_q);
  assign div_sec   = div_small({1'b0, sec_q}, 6'd60);
  assign div_min   = div_small(min_q, 6'd60);
  assign div_hr    = div_small(hour_q, 6'd24);
  assign leap      = (year_q[1:0] == 2'd0) && ((ymod_q != 7'd0) || (ycent_q == 2'd0));
  assign dim       = days_in_month(month_q, leap);
  assign month_inc = month_q + 8'd1;

  assign sts_o.advance  = (kind_q == CMD_LOAD) || (loaded_q && tick_roll);
  assign sts_o.day_done = (day_q <= {4'd0, dim});
  assign sts_o.out_full = m_valid_q && !m_tready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) raw_q <= s_tdata_i;
    if (cmd_i.out_load) begin
      m_data_q <= {4'd0, sec_q[5:0], min_q[5:0], hour_q[4:0], day_q[4:0], month_q, year_q};
      m_user_q <= loaded_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q    <= CMD_LOAD;
      tps_q     <= TpsReset;
      sub_q     <= '0;
      year_q    <= '0;
      ymod_q    <= '0;
      ycent_q   <= '0;
      month_q   <= '0;
      day_q     <= '0;
      hour_q    <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      loaded_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) tps_q <= cfg_wdata_i;
      if (cmd_i.capture) kind_q <= cmd_e'(s_tuser_i);

      if (cmd_i.start) begin
        if (kind_q == CMD_LOAD) begin
          year_q   <= year_load;
          ymod_q   <= yr_rem;
          ycent_q  <= ycent_load;
          month_q  <= mon_dec;
          day_q    <= {1'b0, day_dec};
          hour_q   <= hr_fix;
          min_q    <= {1'b0, min_dec};
          sec_q    <= sec_dec;
          sub_q    <= '0;
          loaded_q <= 1'b1;
        end else if (loaded_q) begin
          if (tick_roll) begin
            sub_q <= '0;
            sec_q <= sec_q + 8'd1;
          end else begin
            sub_q <= sub_inc;
          end
        end
      end

      if (cmd_i.step_sec) begin
        sec_q <= div_sec.r[7:0];
        min_q <= min_q + 9'(div_sec.q);
      end
      if (cmd_i.step_min) begin
        min_q  <= div_min.r;
        hour_q <= hour_q + 9'(div_min.q);
      end
      if (cmd_i.step_hr) begin
        hour_q <= div_hr.r;
        day_q  <= day_q + 9'(div_hr.q);
      end

      // one month per cycle until the day fits
      if (cmd_i.step_day && !sts_o.day_done) begin
        day_q <= day_q - {4'd0, dim};
        if (month_inc > 8'd12) begin
          month_q <= 8'd1;
          if (year_q == 14'h3FFF) begin
            year_q  <= '0;
            ymod_q  <= '0;
            ycent_q <= '0;
          end else begin
            year_q <= year_q + 14'd1;
            if (ymod_q == 7'd99) begin
              ymod_q  <= '0;
              ycent_q <= ycent_q + 2'd1;
            end else begin
              ymod_q <= ymod_q + 7'd1;
            end
          end
        end else begin
          month_q <= month_inc;
        end
      end

      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;
  assign m_tuser_o  = m_user_q;

  `RTC_ASSERT_IMPL(a_norm_at_out, cmd_i.out_load, sec_q < 8'd60 && min_q < 9'd60 && hour_q < 9'd24 && day_q <= 9'd31, "result not normalized")
  `RTC_ASSERT(a_ymod_range, ymod_q < 7'd100, "year mod 100 tracker out of range")
  `RTC_ASSERT_IMPL(a_ymod_tracks, year_q[1:0] == 2'd0 && ymod_q[1:0] != 2'd0, 1'b0, "year mod 100 tracker out of step with year")

endmodule

`default_nettype wire

@@ design/rtc_calendar_time_keeper.sv @@
// ----------------------------------------------------------------------------
// rtc_calendar_time_keeper
// Calendar and time-of-day keeper fed by clock-chip snapshots and timer ticks.
// ----------------------------------------------------------------------------
// One request is worked on at a time and gives one result. A tick that does
// not complete a second (or comes before any snapshot) goes from decode
// straight to the result register. A snapshot load, or a tick that adds a
// second, also runs the carry steps and the day carry loop, which passes one
// month per cycle through the month-length lookup: none for a tick within a
// month, one at a month end, at most 8 for a snapshot with an out-of-range day.
// The result waits in an output register, so the next request is accepted
// while it is still pending. The ticks-per-second register is to be written
// through cfg_we_i/cfg_wdata_i only while the block is idle (not enforced by
// the block itself); a value of zero acts as one.
`default_nettype none

module rtc_calendar_time_keeper
  import rtc_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [TpsW-1:0]     cfg_wdata_i,     // ticks_per_second
  input  wire logic                s_axis_tvalid_i,
  output logic                     s_axis_tready_o,
  // [7:0] raw_seconds, [15:8] raw_minutes, [23:16] raw_hours, [31:24] raw_day,
  // [39:32] raw_month, [47:40] raw_year, [55:48] raw_century,
  // [63:56] raw_status_b
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  input  wire logic [0:0]          s_axis_tuser_i,  // [0] command
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // [13:0] year, [21:14] month, [26:22] day, [31:27] hour, [37:32] minute,
  // [43:38] second, [47:44] zero
  output logic [OutDataW-1:0]      m_axis_tdata_o,
  output logic [0:0]               m_axis_tuser_o   // [0] valid_res
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      accept_ready;

  rtc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (accept_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rtc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata_i),
    .s_tuser_i   (s_axis_tuser_i[0]),
    .m_tready_i  (m_axis_tready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tvalid_o  (m_axis_tvalid_o),
    .m_tdata_o   (m_axis_tdata_o),
    .m_tuser_o   (m_axis_tuser_o[0])
  );

  assign s_axis_tready_o = accept_ready;

endmodule

`default_nettype wire

@@ test/rtc_calendar_time_keeper_tb.sv @@
// ----------------------------------------------------------------------------
// rtc_calendar_time_keeper_tb
// Drives clock-chip snapshots and timer ticks into the calendar keeper over
// the input stream, with random gaps on both sides, and checks every result
// against a cycle-free calendar predictor or a reading given in the table. A
// short directed table comes first (reset state, 12/24-hour and BCD/binary
// decoding, century substitution, leap years, out-of-range fields, odd tick
// rates), then random phases, each at its own ticks-per-second setting.
// ----------------------------------------------------------------------------
`default_nettype none

module rtc_calendar_time_keeper_tb;
  import rtc_pkg::*;

  localparam logic [7:0] STB_24H    = 8'h02;
  localparam logic [7:0] STB_BINARY = 8'h04;
  localparam logic [7:0] HOUR_PM    = 8'h80;
  localparam int unsigned YEAR_MASK = 32'h3FFF;
  localparam int unsigned SETTLE_CYCLES = 20;

  // laid out to match {m_axis_tuser_o, m_axis_tdata_o}
  typedef struct packed {
    logic       valid;
    logic [3:0] spare;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [4:0] day;
    logic [7:0] month;
    logic [13:0] year;
  } clock_reading_t;

  typedef struct {
    bit             cfg;
    logic [15:0]    tps;
    cmd_e           cmd;
    logic [63:0]    data;
    bit             typed;
    clock_reading_t want;
  } stim_row_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [TpsW-1:0]     cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_tdata = '0;
  logic [0:0]          s_tuser = '0;
  logic                m_axis_tvalid_o;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [0:0]          m_axis_tuser_o;

  rtc_calendar_time_keeper dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Calendar predictor
  // --------------------------------------------------------------------------
  int unsigned tps_setting = 100;
  int unsigned cal_year, cal_month, cal_day, cal_hour, cal_min, cal_sec;
  int unsigned sub_ticks;
  bit          clock_set;

  clock_reading_t pending_readings[$];
  int unsigned    flaws;

  function automatic int unsigned bcd_decode(input int unsigned v);
    return (v & 32'hF) + 10 * ((v >> 4) & 32'hF);
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    if (m == 2) return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  function automatic void roll_forward(input int unsigned add);
    int unsigned carry;
    int unsigned mlen;
    carry    = cal_sec + add;
    cal_sec  = carry % 60;
    carry    = cal_min + carry / 60;
    cal_min  = carry % 60;
    carry    = cal_hour + carry / 60;
    cal_hour = carry % 24;
    cal_day  = cal_day + carry / 24;
    mlen = month_length(cal_year, cal_month);
    while (cal_day > mlen) begin
      cal_day   = cal_day - mlen;
      cal_month = (cal_month + 1) & 32'hFF;
      // month 255 wraps to 0, which is not past December
      if (cal_month > 12) begin
        cal_month = 1;
        cal_year  = (cal_year + 1) & YEAR_MASK;
      end
      mlen = month_length(cal_year, cal_month);
    end
  endfunction

  function automatic void take_snapshot(input logic [63:0] d);
    int unsigned sec, min, hr, day, mon, yr, cent;
    logic [7:0]  stb;
    bit          twelve;
    bit          pm;
    sec  = d[7:0];
    min  = d[15:8];
    hr   = d[23:16];
    day  = d[31:24];
    mon  = d[39:32];
    yr   = d[47:40];
    cent = d[55:48];
    stb  = d[63:56];
    twelve = (stb & STB_24H) == 0;
    pm = 1'b0;
    if (twelve) begin
      pm = (hr & HOUR_PM) != 0;
      hr = hr & 32'h7F;
    end
    if ((stb & STB_BINARY) == 0) begin
      sec  = bcd_decode(sec);
      min  = bcd_decode(min);
      hr   = bcd_decode(hr);
      day  = bcd_decode(day);
      mon  = bcd_decode(mon);
      yr   = bcd_decode(yr);
      cent = bcd_decode(cent);
    end
    if (twelve) begin
      if (hr == 12) hr = pm ? 12 : 0;
      else if (pm) hr = hr + 12;
    end
    if (cent < 19 || cent > 99) cent = 20;
    cal_year  = (yr + cent * 100) & YEAR_MASK;
    cal_month = mon;
    cal_day   = day;
    cal_hour  = hr;
    cal_min   = min;
    cal_sec   = sec;
    roll_forward(0);
    sub_ticks = 0;
    clock_set = 1'b1;
  endfunction

  function automatic void count_tick();
    if (clock_set) begin
      sub_ticks = (sub_ticks + 1) & 32'hFFFF;
      // a rate of zero, or one lowered below the count, fires right away
      if (sub_ticks >= tps_setting) begin
        sub_ticks = 0;
        roll_forward(1);
      end
    end
  endfunction

  function automatic clock_reading_t step_calendar(input cmd_e cmd, input logic [63:0] d);
    clock_reading_t r;
    if (cmd == CMD_LOAD) take_snapshot(d);
    else count_tick();
    r.valid  = clock_set;
    r.spare  = '0;
    r.second = 6'(cal_sec);
    r.minute = 6'(cal_min);
    r.hour   = 5'(cal_hour);
    r.day    = 5'(cal_day);
    r.month  = 8'(cal_month);
    r.year   = 14'(cal_year);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic clock_reading_t reading(input int y, input int mo, input int d,
                                             input int h, input int mi, input int s,
                                             input bit v);
    clock_reading_t r;
    r = '{valid: v, spare: 4'd0, second: 6'(s), minute: 6'(mi), hour: 5'(h),
          day: 5'(d), month: 8'(mo), year: 14'(y)};
    return r;
  endfunction

  function automatic string show(input clock_reading_t r);
    return $sformatf("%0d-%0d-%0d %0d:%0d:%0d valid=%0d spare=%0h", r.year, r.month,
                     r.day, r.hour, r.minute, r.second, r.valid, r.spare);
  endfunction

  function automatic logic [63:0] pack_raw(input logic [7:0] sec, input logic [7:0] min,
                                           input logic [7:0] hr, input logic [7:0] day,
                                           input logic [7:0] mon, input logic [7:0] yr,
                                           input logic [7:0] cent, input logic [7:0] stb);
    return {stb, cent, yr, mon, day, hr, min, sec};
  endfunction

  function automatic logic [7:0] enc_field(input int unsigned v, input bit binary);
    return binary ? 8'(v) : {4'(v / 10), 4'(v % 10)};
  endfunction

  // mostly well-formed snapshots, biased toward the end of a day or month
  function automatic logic [63:0] random_snapshot();
    int unsigned kind, cent, yr, mon, day, hr, min, sec, eff, h12;
    bit          binary, h24;
    logic [7:0]  hr_byte, stb;
    kind = $urandom_range(0, 99);
    if (kind < 25) return {$urandom, $urandom};
    binary = $urandom_range(0, 1);
    h24    = $urandom_range(0, 1);
    yr     = $urandom_range(0, 99);
    case ($urandom_range(0, 4))
      0:       cent = 19;
      1:       cent = 20;
      2:       cent = 99;
      3:       cent = $urandom_range(0, 99);
      default: cent = 21;
    endcase
    eff = (cent < 19 || cent > 99) ? 20 : cent;
    mon = $urandom_range(1, 12);
    if (kind < 40) begin
      mon = $urandom_range(0, 15);
      day = $urandom_range(0, 40);
      hr  = $urandom_range(0, 30);
      min = $urandom_range(0, 70);
      sec = $urandom_range(0, 70);
    end else begin
      day = $urandom_range(0, 1) ? month_length(eff * 100 + yr, mon)
                                 : $urandom_range(1, month_length(eff * 100 + yr, mon));
      hr  = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
      min = $urandom_range(0, 1) ? 59 : $urandom_range(0, 59);
      sec = $urandom_range(0, 1) ? $urandom_range(50, 59) : $urandom_range(0, 59);
    end
    if (h24) begin
      hr_byte = enc_field(hr, binary);
    end else begin
      hr  = hr % 24;
      h12 = (hr % 12 == 0) ? 12 : hr % 12;
      hr_byte = enc_field(h12, binary) | ((hr >= 12) ? HOUR_PM : 8'h00);
    end
    stb = 8'($urandom_range(0, 255)) & ~(STB_24H | STB_BINARY);
    stb = stb | (h24 ? STB_24H : 8'h00) | (binary ? STB_BINARY : 8'h00);
    return pack_raw(enc_field(sec, binary), enc_field(min, binary), hr_byte,
                    enc_field(day, binary), enc_field(mon, binary), enc_field(yr, binary),
                    enc_field(cent, binary), stb);
  endfunction

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  bit          tx_calm;
  int unsigned tx_left;

  task automatic send_request(input cmd_e cmd, input logic [63:0] data, input bit typed,
                              input clock_reading_t want);
    int unsigned    gap;
    clock_reading_t predicted;
    if (tx_left == 0) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      tx_left = $urandom_range(8, 40);
    end
    tx_left = tx_left - 1;
    gap = tx_calm ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = step_calendar(cmd, data);
    pending_readings.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(input logic [15:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    tps_setting = value;
  endtask

  stim_row_t plan[$];

  function automatic void add_cfg(input logic [15:0] value);
    plan.push_back('{cfg: 1'b1, tps: value, cmd: CMD_TICK, data: '0, typed: 1'b0,
                     want: '0});
  endfunction

  function automatic void add_req(input cmd_e cmd, input logic [63:0] data);
    plan.push_back('{cfg: 1'b0, tps: '0, cmd: cmd, data: data, typed: 1'b0, want: '0});
  endfunction

  function automatic void add_checked(input cmd_e cmd, input logic [63:0] data,
                                      input clock_reading_t want);
    plan.push_back('{cfg: 1'b0, tps: '0, cmd: cmd, data: data, typed: 1'b1, want: want});
  endfunction

  initial begin
    logic [15:0] tps_plan [10];
    int unsigned ph, i, count;
    tps_plan = '{16'd1, 16'd2, 16'd0, 16'd3, 16'hFFFF, 16'd1, 16'd100, 16'd4, 16'd1, 16'd7};

    // ticks before the first snapshot do nothing
    add_checked(CMD_TICK, '0, reading(0, 0, 0, 0, 0, 0, 0));
    add_checked(CMD_TICK, '1, reading(0, 0, 0, 0, 0, 0, 0));
    // 12-hour BCD: 12 AM, 12 PM, 11 PM, 1 AM
    add_req(CMD_LOAD, pack_raw(8'h30, 8'h45, 8'h12, 8'h15, 8'h06, 8'h24, 8'h20, 8'h00));
    add_req(CMD_LOAD, pack_raw(8'h00, 8'h00, 8'h92, 8'h01, 8'h01, 8'h24, 8'h20, 8'h00));
    add_req(CMD_LOAD, pack_raw(8'h59, 8'h59, 8'h91, 8'h31, 8'h01, 8'h24, 8'h20, 8'hF8));
    add_req(CMD_LOAD, pack_raw(8'h05, 8'h07, 8'h01, 8'h09, 8'h09, 8'h24, 8'h20, 8'h00));
    add_checked(CMD_LOAD, pack_raw(8'd59, 8'd59, 8'd23, 8'd31, 8'd12, 8'd99, 8'd99, 8'h06),
                reading(9999, 12, 31, 23, 59, 59, 1));
    add_cfg(16'd1);
    add_checked(CMD_TICK, '0, reading(10000, 1, 1, 0, 0, 0, 1));
    // century below 19 falls back to 20; leap day in 2000, none in 1900
    add_req(CMD_LOAD, pack_raw(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h00, 8'h18, 8'h02));
    add_req(CMD_TICK, '0);
    add_req(CMD_LOAD, pack_raw(8'h59, 8'h59, 8'h23, 8'h28, 8'h02, 8'h00, 8'h19, 8'h02));
    add_req(CMD_TICK, '0);
    add_req(CMD_LOAD, '1);
    add_req(CMD_LOAD, '0);
    add_req(CMD_TICK, '0);
    // month 13 with day 32, binary 12-hour PM hours, month 0 and month 255
    add_req(CMD_LOAD, pack_raw(8'd0, 8'd0, 8'd0, 8'd32, 8'd13, 8'd50, 8'd20, 8'h06));
    add_req(CMD_LOAD, pack_raw(8'd10, 8'd20, 8'h8C, 8'd5, 8'd5, 8'd5, 8'd20, 8'h04));
    add_req(CMD_LOAD, pack_raw(8'd10, 8'd20, 8'h8B, 8'd5, 8'd5, 8'd5, 8'd20, 8'h04));
    add_req(CMD_LOAD, pack_raw(8'd0, 8'd0, 8'd0, 8'd15, 8'd0, 8'd0, 8'd20, 8'h06));
    add_req(CMD_LOAD, pack_raw(8'd0, 8'd0, 8'd0, 8'd40, 8'd255, 8'd0, 8'd20, 8'h06));
    add_cfg(16'd0);
    add_req(CMD_LOAD, pack_raw(8'd58, 8'd0, 8'd0, 8'd1, 8'd1, 8'd0, 8'd20, 8'h06));
    add_req(CMD_TICK, '0);
    add_req(CMD_TICK, '0);
    // slowest rate, then lowered below the running count
    add_cfg(16'hFFFF);
    add_req(CMD_TICK, '0);
    add_req(CMD_TICK, '0);
    add_cfg(16'd1);
    add_req(CMD_TICK, '0);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].cfg) configure(plan[k].tps);
      else send_request(plan[k].cmd, plan[k].data, plan[k].typed, plan[k].want);
    end

    for (ph = 0; ph < 10; ph++) begin
      configure(tps_plan[ph]);
      count = (tps_plan[ph] == 16'hFFFF) ? 40 : 110;
      for (i = 0; i < count; i++) begin
        if (i == count / 2) drain();
        if (i == 0 || $urandom_range(0, 99) < 8)
          send_request(CMD_LOAD, random_snapshot(), 1'b0, '0);
        else
          send_request(CMD_TICK, {$urandom, $urandom}, 1'b0, '0);
      end
    end

    s_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (flaws == 0 && pending_readings.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver and checker
  // --------------------------------------------------------------------------
  initial begin
    int unsigned stall, rx_left;
    bit          rx_calm;
    rx_left = 0;
    rx_calm = 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (rx_left == 0) begin
        rx_calm = ($urandom_range(0, 3) == 0);
        rx_left = $urandom_range(8, 40);
      end
      rx_left = rx_left - 1;
      stall = rx_calm ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  clock_reading_t seen_reading, due_reading;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      seen_reading = {m_axis_tuser_o, m_axis_tdata_o};
      if (pending_readings.size() == 0) begin
        flaws++;
        if (flaws <= 10) $display("unrequested result: %s", show(seen_reading));
      end else begin
        due_reading = pending_readings.pop_front();
        if (seen_reading !== due_reading) begin
          flaws++;
          if (flaws <= 10)
            $display("result mismatch: expected %s, got %s", show(due_reading),
                     show(seen_reading));
        end
      end
    end
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/rtc_pkg.sv
design/rtc_ctrl.sv
design/rtc_dp.sv
design/rtc_calendar_time_keeper.sv
test/rtc_calendar_time_keeper_tb.sv
